[design/cwfb_pkg.sv]
// ----------------------------------------------------------------------------
// cwfb_pkg
// Shared types, constants and helper functions for the control word frame
// builder: item modes, register indexes, frame snapshot and byte layout.
// ----------------------------------------------------------------------------
package cwfb_pkg;

    // Field widths
    localparam int MODE_W    = 3;
    localparam int VALUE_W   = 16;
    localparam int BYTE_W    = 8;
    localparam int CW_W      = 32;
    localparam int SEQ_W     = 16;
    localparam int LIGHT_W   = 3;
    localparam int TRIM_W    = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 8;

    // Frame layout
    localparam int FRAME_LEN  = 20;
    localparam int IDX_W      = $clog2(FRAME_LEN);
    localparam int SUM_LAST   = 17;
    localparam int HEX_FIRST  = 11;

    // Snapshot queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Control word defaults
    localparam logic [CW_W-1:0]   CW_DEFAULT  = 32'h007f_7f0a;
    localparam logic [CW_W-1:0]   CW_OFF      = 32'h007f_7fea;
    localparam logic [23:0]       CW_UPPER_DEF = 24'h007f7f;
    localparam logic [BYTE_W-1:0] CW_LOW_DEF  = 8'h0a;

    // Reset values of the limit registers
    localparam logic [BYTE_W-1:0] LIMIT_RESET = 8'hff;
    localparam logic [TRIM_W-1:0] TRIM_RESET  = 5'h1f;

    // Fixed frame bytes
    localparam logic [BYTE_W-1:0] HDR_SYNC  = 8'h55;
    localparam logic [BYTE_W-1:0] HDR_ADDR  = 8'h11;
    localparam logic [BYTE_W-1:0] HDR_ZERO  = 8'h00;
    localparam logic [BYTE_W-1:0] HDR_CMD   = 8'h43;
    localparam logic [BYTE_W-1:0] HDR_ONE   = 8'h01;
    localparam logic [BYTE_W-1:0] HDR_X     = 8'h78;
    localparam logic [BYTE_W-1:0] HDR_DIGIT = 8'h30;

    typedef enum logic [MODE_W-1:0] {
        MODE_THROTTLE = 3'd0,
        MODE_PITCH    = 3'd1,
        MODE_YAW      = 3'd2,
        MODE_LIGHT    = 3'd3,
        MODE_TRIM_DN  = 3'd4,
        MODE_TRIM_UP  = 3'd5,
        MODE_OFF      = 3'd6,
        MODE_TICK     = 3'd7
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THROTTLE_LIMIT = 2'd0,
        CFG_PITCH_LIMIT    = 2'd1,
        CFG_YAW_LIMIT      = 2'd2,
        CFG_TRIM_LIMIT     = 2'd3
    } t_cfg_idx;

    // What one tick hands to the frame sequencer
    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [CW_W-1:0]  cw;
    } t_snap;

    // Queue status seen by both sides
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    // Lowercase ASCII hex digit of one nibble
    function automatic logic [BYTE_W-1:0] hex_ascii(input logic [3:0] nib);
        logic [BYTE_W-1:0] ext;
        ext = {4'h0, nib};
        hex_ascii = (nib < 4'd10) ? (8'h30 + ext) : (8'h57 + ext);
    endfunction

    // Frame byte at a given position (checksum position excluded)
    function automatic logic [BYTE_W-1:0] frame_byte(input logic [IDX_W-1:0] idx,
                                                     input logic [SEQ_W-1:0] seq,
                                                     input logic [CW_W-1:0]  cw);
        logic [BYTE_W-1:0] b;
        case (idx)
            5'd0:    b = HDR_SYNC;
            5'd1:    b = HDR_ADDR;
            5'd2:    b = HDR_ZERO;
            5'd3:    b = HDR_CMD;
            5'd4:    b = seq[15:8];
            5'd5:    b = seq[7:0];
            5'd6:    b = HDR_ZERO;
            5'd7:    b = HDR_ONE;
            5'd8:    b = HDR_X;
            5'd9:    b = HDR_DIGIT;
            5'd10:   b = HDR_DIGIT;
            5'd11:   b = hex_ascii(cw[31:28]);
            5'd12:   b = hex_ascii(cw[27:24]);
            5'd13:   b = hex_ascii(cw[23:20]);
            5'd14:   b = hex_ascii(cw[19:16]);
            5'd15:   b = hex_ascii(cw[15:12]);
            5'd16:   b = hex_ascii(cw[11:8]);
            5'd17:   b = hex_ascii(cw[7:4]);
            5'd18:   b = hex_ascii(cw[3:0]);
            default: b = HDR_ZERO;
        endcase
        frame_byte = b;
    endfunction

endpackage

[design/cwfb_front.sv]
// ----------------------------------------------------------------------------
// cwfb_front
// Accepts mode items, holds the limit registers, the control word, the light
// counter and the sequence number, and queues a snapshot on every tick.
// ----------------------------------------------------------------------------
module cwfb_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cwfb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cwfb_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [cwfb_pkg::MODE_W-1:0]   i_mode,
    input  logic signed [cwfb_pkg::VALUE_W-1:0] i_value,
    input  cwfb_pkg::t_q_status           i_q_status,
    output logic                          o_push,
    output cwfb_pkg::t_snap               o_snap
);
    import cwfb_pkg::*;

    logic [BYTE_W-1:0]  r_thr_limit, r_pitch_limit, r_yaw_limit;
    logic [TRIM_W-1:0]  r_trim_limit;
    logic [CW_W-1:0]    r_cw, n_cw;
    logic [LIGHT_W-1:0] r_light, n_light;
    logic [SEQ_W-1:0]   r_seq, n_seq;
    logic               accept;
    logic [BYTE_W-1:0]  thr_val, pitch_val, yaw_val;
    logic [TRIM_W:0]    trim_inc;
    logic [TRIM_W-1:0]  trim_dec;

    // Clamp the signed request to zero and the limit
    function automatic logic [BYTE_W-1:0] clamp(input logic signed [VALUE_W-1:0] val,
                                                input logic [BYTE_W-1:0] lim);
        logic [VALUE_W-1:0] lim_ext;
        lim_ext = {{(VALUE_W-BYTE_W){1'b0}}, lim};
        if (val[VALUE_W-1]) begin
            clamp = '0;
        end else if ($unsigned(val) > lim_ext) begin
            clamp = lim;
        end else begin
            clamp = val[BYTE_W-1:0];
        end
    endfunction

    // Stall only when no room is left for a tick snapshot
    assign o_ready = !i_q_status.full;
    assign accept  = i_valid && o_ready;

    assign thr_val   = clamp(i_value, r_thr_limit);
    assign pitch_val = clamp(i_value, r_pitch_limit);
    assign yaw_val   = clamp(i_value, r_yaw_limit);
    assign trim_inc  = {1'b0, r_cw[TRIM_W-1:0]} + 6'd1;
    assign trim_dec  = (r_cw[TRIM_W-1:0] != '0) ? (r_cw[TRIM_W-1:0] - 5'd1) : '0;

    // Decode the item and work out the new control state
    always_comb begin
        n_cw    = r_cw;
        n_light = r_light;
        n_seq   = r_seq;
        o_push  = 1'b0;
        if (accept) begin
            case (t_mode'(i_mode))
                MODE_THROTTLE: begin
                    if (thr_val == '0) begin
                        n_cw = {CW_UPPER_DEF, r_cw[BYTE_W-1:0] | CW_LOW_DEF};
                    end else begin
                        n_cw = {thr_val, r_cw[23:0]};
                    end
                end
                MODE_PITCH: n_cw = {r_cw[31:24], pitch_val, r_cw[15:0]};
                MODE_YAW:   n_cw = {r_cw[31:16], yaw_val, r_cw[7:0]};
                MODE_LIGHT: begin
                    n_light = r_light + 3'd1;
                    n_cw    = {r_cw[31:8], n_light, r_cw[TRIM_W-1:0]};
                end
                MODE_TRIM_DN: n_cw = {r_cw[31:TRIM_W], trim_dec};
                MODE_TRIM_UP: begin
                    if (trim_inc > {1'b0, r_trim_limit}) begin
                        n_cw = {r_cw[31:TRIM_W], r_trim_limit};
                    end else begin
                        n_cw = {r_cw[31:TRIM_W], trim_inc[TRIM_W-1:0]};
                    end
                end
                MODE_OFF: n_cw = CW_OFF;
                MODE_TICK: begin
                    n_seq  = r_seq + 16'd1;
                    o_push = 1'b1;
                end
                default: n_cw = r_cw;
            endcase
        end
    end

    assign o_snap.seq = n_seq;
    assign o_snap.cw  = r_cw;

    // Hold control state and limits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cw          <= CW_DEFAULT;
            r_light       <= '0;
            r_seq         <= '0;
            r_thr_limit   <= LIMIT_RESET;
            r_pitch_limit <= LIMIT_RESET;
            r_yaw_limit   <= LIMIT_RESET;
            r_trim_limit  <= TRIM_RESET;
        end else begin
            r_cw    <= n_cw;
            r_light <= n_light;
            r_seq   <= n_seq;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_THROTTLE_LIMIT: r_thr_limit   <= i_cfg_data;
                    CFG_PITCH_LIMIT:    r_pitch_limit <= i_cfg_data;
                    CFG_YAW_LIMIT:      r_yaw_limit   <= i_cfg_data;
                    CFG_TRIM_LIMIT:     r_trim_limit  <= i_cfg_data[TRIM_W-1:0];
                    default:            r_thr_limit   <= r_thr_limit;
                endcase
            end
        end
    end

endmodule

[design/cwfb_queue.sv]
// ----------------------------------------------------------------------------
// cwfb_queue
// Short first-in first-out queue of tick snapshots between the front end and
// the frame sequencer.
// ----------------------------------------------------------------------------
module cwfb_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  cwfb_pkg::t_snap      i_wdata,
    input  logic                 i_pop,
    output cwfb_pkg::t_snap      o_rdata,
    output cwfb_pkg::t_q_status  o_status
);
    import cwfb_pkg::*;

    t_snap             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QPTR_W:0]   r_count;
    logic              do_push, do_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_rdata        = r_mem[r_rptr];

    // Store the snapshot
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[design/cwfb_back.sv]
// ----------------------------------------------------------------------------
// cwfb_back
// Frame sequencer: takes one snapshot from the queue and sends its twenty
// bytes, one beat per cycle while i_ready is high, and builds the checksum.
// ----------------------------------------------------------------------------
module cwfb_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cwfb_pkg::t_snap             i_snap,
    input  cwfb_pkg::t_q_status         i_q_status,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [cwfb_pkg::BYTE_W-1:0] o_byte,
    output logic                        o_last
);
    import cwfb_pkg::*;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_LEN - 1);
    localparam logic [IDX_W-1:0] IDX_SUM  = IDX_W'(SUM_LAST);

    logic              r_active;
    logic [IDX_W-1:0]  r_idx;
    logic [SEQ_W-1:0]  r_seq;
    logic [CW_W-1:0]   r_cw;
    logic [BYTE_W-1:0] r_sum;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;
    logic              advance;
    logic [BYTE_W-1:0] cur_byte;

    // Output register frees up when empty or taken
    assign advance  = !r_out_valid || i_ready;
    assign o_pop    = advance && !r_active && !i_q_status.empty;
    assign cur_byte = (r_idx == IDX_LAST) ? (8'h00 - r_sum) : frame_byte(r_idx, r_seq, r_cw);

    // Step through the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_idx       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else if (advance) begin
            if (r_active) begin
                r_out_valid <= 1'b1;
                r_out_byte  <= cur_byte;
                r_out_last  <= (r_idx == IDX_LAST);
                r_idx       <= r_idx + 1'b1;
                if (r_idx <= IDX_SUM) begin
                    r_sum <= r_sum + cur_byte;
                end
                if (r_idx == IDX_LAST) begin
                    r_active <= 1'b0;
                end
            end else if (o_pop) begin
                // Send the sync byte and latch the snapshot
                r_out_valid <= 1'b1;
                r_out_byte  <= HDR_SYNC;
                r_out_last  <= 1'b0;
                r_active    <= 1'b1;
                r_idx       <= IDX_W'(1);
                r_sum       <= '0;
                r_seq       <= i_snap.seq;
                r_cw        <= i_snap.cw;
            end else begin
                r_out_valid <= 1'b0;
                r_out_last  <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_idx != '0) && (r_idx <= IDX_LAST))
        else $error("frame position out of range");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_q_status.empty)
        else $error("snapshot taken from an empty queue");

    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> !r_active)
        else $error("checksum beat while a frame is still running");

    a_start_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_active) |-> $past(o_pop))
        else $error("frame started without a snapshot");

endmodule

[design/control_word_frame_builder_unit.sv]
// ----------------------------------------------------------------------------
// control_word_frame_builder_unit
// Keeps a 32-bit control word and emits a 20-byte command frame per tick.
// ----------------------------------------------------------------------------
// Mode beats (throttle, pitch, yaw, light, trim down/up, off) are taken one
// per cycle while the snapshot queue is not full and update the control word
// at once; they produce no output. A tick beat bumps the sequence number and
// queues a snapshot of it and the control word; the frame sequencer then
// sends 20 byte beats, one per cycle while tready is high, with tlast on the
// checksum byte. The snapshot queue holds two ticks, so the input stalls only
// when two frames already wait behind the one being sent. Limit registers
// must be written through i_cfg_* while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module control_word_frame_builder_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [cwfb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cwfb_pkg::CFG_W-1:0]    i_cfg_data,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [15:0]                   s_axis_tdata,  // [15:0] set_value (signed)
    input  logic [2:0]                    s_axis_tuser,  // [2:0] mode
    // frame byte stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,  // [7:0] frame_byte
    output logic                          m_axis_tlast
);
    import cwfb_pkg::*;

    t_q_status q_status;
    t_snap     push_snap, head_snap;
    logic      push, pop;

    cwfb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_mode     (s_axis_tuser),
        .i_value    ($signed(s_axis_tdata)),
        .i_q_status (q_status),
        .o_push     (push),
        .o_snap     (push_snap)
    );

    cwfb_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_wdata  (push_snap),
        .i_pop    (pop),
        .o_rdata  (head_snap),
        .o_status (q_status)
    );

    cwfb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_snap     (head_snap),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_byte     (m_axis_tdata),
        .o_last     (m_axis_tlast)
    );

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for control_word_frame_builder_unit. Mode and tick
// beats go in on the slave stream; a tracker class keeps its own control
// word, light counter, sequence number and limits, builds the 20 expected
// frame bytes for every tick and compares each byte beat that leaves the
// master stream. The run covers a directed opening, then random phases under
// several limit settings.
// ----------------------------------------------------------------------------
module tb;
    import cwfb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 200;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_ITEMS   = 410;
    localparam int PHASES         = 5;

    // Tracks the control word and the frames it must produce
    class frame_tracker;
        logic [7:0]  throttle_cap;
        logic [7:0]  pitch_cap;
        logic [7:0]  yaw_cap;
        logic [4:0]  trim_cap;
        logic [31:0] ctrl_word;
        logic [2:0]  light_step;
        logic [15:0] frame_seq;
        logic [7:0]  frame_bytes_due[$];
        logic        frame_end_due[$];
        int          mismatches;

        function new();
            throttle_cap = LIMIT_RESET;
            pitch_cap    = LIMIT_RESET;
            yaw_cap      = LIMIT_RESET;
            trim_cap     = TRIM_RESET;
            ctrl_word    = CW_DEFAULT;
            light_step   = '0;
            frame_seq    = '0;
            mismatches   = 0;
        endfunction

        function void set_limit(t_cfg_idx idx, logic [7:0] data);
            case (idx)
                CFG_THROTTLE_LIMIT: throttle_cap = data;
                CFG_PITCH_LIMIT:    pitch_cap    = data;
                CFG_YAW_LIMIT:      yaw_cap      = data;
                CFG_TRIM_LIMIT:     trim_cap     = data[4:0];
                default: ;
            endcase
        endfunction

        // Negative requests go to zero, large ones to the limit
        function logic [7:0] clamp_to(logic [15:0] req, logic [7:0] lim);
            if (req[15])
                return 8'h00;
            if (req > {8'h00, lim})
                return lim;
            return req[7:0];
        endfunction

        function void take_item(t_mode mode, logic [15:0] req);
            string      digits = "0123456789abcdef";
            logic [7:0] pick;
            logic [5:0] trim_next;
            logic [7:0] frame [FRAME_LEN];
            logic [7:0] sum;
            case (mode)
                MODE_THROTTLE: begin
                    pick = clamp_to(req, throttle_cap);
                    // throttle of zero restores the default upper bytes
                    if (pick == 8'h00)
                        ctrl_word = {CW_UPPER_DEF, ctrl_word[7:0] | CW_LOW_DEF};
                    else
                        ctrl_word[31:24] = pick;
                end
                MODE_PITCH: ctrl_word[23:16] = clamp_to(req, pitch_cap);
                MODE_YAW:   ctrl_word[15:8]  = clamp_to(req, yaw_cap);
                MODE_LIGHT: begin
                    light_step      = light_step + 3'd1;
                    ctrl_word[7:5]  = light_step;
                end
                MODE_TRIM_DN: begin
                    if (ctrl_word[4:0] != 5'd0)
                        ctrl_word[4:0] = ctrl_word[4:0] - 5'd1;
                end
                MODE_TRIM_UP: begin
                    // may also pull a trim above the limit down to it
                    trim_next = {1'b0, ctrl_word[4:0]} + 6'd1;
                    if (trim_next > {1'b0, trim_cap})
                        trim_next = {1'b0, trim_cap};
                    ctrl_word[4:0] = trim_next[4:0];
                end
                MODE_OFF: ctrl_word = CW_OFF;
                default: begin
                    frame_seq = frame_seq + 16'd1;
                    frame[0]  = HDR_SYNC;
                    frame[1]  = HDR_ADDR;
                    frame[2]  = HDR_ZERO;
                    frame[3]  = HDR_CMD;
                    frame[4]  = frame_seq[15:8];
                    frame[5]  = frame_seq[7:0];
                    frame[6]  = HDR_ZERO;
                    frame[7]  = HDR_ONE;
                    frame[8]  = HDR_X;
                    frame[9]  = HDR_DIGIT;
                    frame[10] = HDR_DIGIT;
                    for (int i = 0; i < 8; i++)
                        frame[11 + i] = digits[ctrl_word[31 - 4 * i -: 4]];
                    // checksum covers bytes 1 to 17 only
                    sum = 8'h00;
                    for (int i = 1; i <= 17; i++)
                        sum = sum + frame[i];
                    frame[FRAME_LEN - 1] = 8'h00 - sum;
                    for (int i = 0; i < FRAME_LEN; i++) begin
                        frame_bytes_due.push_back(frame[i]);
                        frame_end_due.push_back(i == FRAME_LEN - 1);
                    end
                end
            endcase
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH %s", $time, msg);
            mismatches++;
        endtask

        task check_frame_byte(logic [7:0] data, logic last);
            logic [7:0] want_byte;
            logic       want_end;
            if (frame_bytes_due.size() == 0) begin
                report($sformatf("unexpected beat byte=%02h last=%0b", data, last));
            end else begin
                want_byte = frame_bytes_due.pop_front();
                want_end  = frame_end_due.pop_front();
                if (data !== want_byte)
                    report($sformatf("frame byte %02h, want %02h", data, want_byte));
                if (last !== want_end)
                    report($sformatf("tlast %0b, want %0b", last, want_end));
            end
        endtask

        function int bytes_owed();
            return frame_bytes_due.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata;   // [15:0] set_value (signed)
    logic [2:0]           s_axis_tuser;   // [2:0] mode
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [7:0]           m_axis_tdata;   // [7:0] frame_byte
    logic                 m_axis_tlast;

    frame_tracker tracker = new();
    bit           no_idle = 1'b0;
    bit           stall_req = 1'b0;
    int           quiet_cycles = 0;

    control_word_frame_builder_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Check each byte beat against the oldest expected frame byte
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_frame_byte(m_axis_tdata, m_axis_tlast);
    end

    // End the run if nothing moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver: random hold bursts, plus one long hold on request
    initial begin : frame_sink
        int hold_left;
        hold_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_req) begin
                stall_req = 1'b0;
                hold_left = LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 9) == 0) begin
                hold_left = $urandom_range(0, 12);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic logic [15:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 255));
            2: return 16'($urandom_range(0, 8));
            3: return 16'($urandom_range(240, 300));
            4: begin
                case ($urandom_range(0, 3))
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    2: return 16'hffff;
                    default: return 16'h0000;
                endcase
            end
            default: return 16'($urandom_range(256, 32767));
        endcase
    endfunction

    // Offer one beat, with an optional idle burst before it
    task automatic send_item(t_mode mode, logic [15:0] req);
        if (!no_idle && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= req;
        s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        tracker.take_item(mode, req);
    endtask

    // Mostly single beats; now and then a run of trims to reach saturation
    task automatic send_random(inout int count);
        int pick;
        int run;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            run = $urandom_range(8, 14);
            repeat (run) send_item(MODE_TRIM_DN, rand_value());
            count += run;
        end else if (pick < 8) begin
            run = $urandom_range(8, 24);
            repeat (run) send_item(MODE_TRIM_UP, rand_value());
            count += run;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 38)
                send_item(MODE_TICK, rand_value());
            else if (pick < 50)
                send_item(MODE_THROTTLE, rand_value());
            else if (pick < 60)
                send_item(MODE_PITCH, rand_value());
            else if (pick < 70)
                send_item(MODE_YAW, rand_value());
            else if (pick < 78)
                send_item(MODE_LIGHT, rand_value());
            else if (pick < 86)
                send_item(MODE_TRIM_DN, rand_value());
            else if (pick < 94)
                send_item(MODE_TRIM_UP, rand_value());
            else
                send_item(MODE_OFF, rand_value());
            count++;
        end
    endtask

    // Drop valid, wait for every frame byte, then let the block settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (tracker.bytes_owed() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [7:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        tracker.set_limit(idx, data);
    endtask

    task automatic write_limits(logic [7:0] thr, logic [7:0] pit, logic [7:0] yaw,
                                logic [7:0] trim);
        write_reg(CFG_THROTTLE_LIMIT, thr);
        write_reg(CFG_PITCH_LIMIT, pit);
        write_reg(CFG_YAW_LIMIT, yaw);
        write_reg(CFG_TRIM_LIMIT, trim);
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        int sent;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_THROTTLE_LIMIT;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= MODE_THROTTLE;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening at the reset limits
        send_item(MODE_TICK, 16'h0000);
        send_item(MODE_THROTTLE, 16'h7fff);
        send_item(MODE_PITCH, 16'h8000);
        send_item(MODE_YAW, 16'h00c8);
        send_item(MODE_TRIM_UP, 16'hffff);
        send_item(MODE_LIGHT, 16'h1234);
        send_item(MODE_TICK, 16'hffff);
        send_item(MODE_THROTTLE, 16'h0000);
        send_item(MODE_TICK, 16'h5a5a);
        send_item(MODE_TRIM_DN, 16'ha5a5);
        send_item(MODE_THROTTLE, 16'hffff);
        send_item(MODE_OFF, 16'h0000);
        send_item(MODE_TICK, 16'h0001);
        send_item(MODE_PITCH, 16'h00ff);
        send_item(MODE_YAW, 16'h0100);
        send_item(MODE_THROTTLE, 16'h0001);
        send_item(MODE_LIGHT, 16'h0000);
        send_item(MODE_LIGHT, 16'h0000);
        send_item(MODE_LIGHT, 16'h0000);
        send_item(MODE_TICK, 16'h8000);
        wait_idle();

        // Random phases, each under its own limits
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: write_limits(8'h00, 8'h00, 8'h00, 8'h00);
                1: write_limits(8'hff, 8'hff, 8'hff, 8'hff);
                default: write_limits(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                      8'($urandom_range(0, 255)), 8'($urandom));
            endcase
            no_idle = (ph == PHASES - 1);
            if (ph == 1)
                stall_req = 1'b1;
            sent = 0;
            while (sent < RANDOM_ITEMS / PHASES)
                send_random(sent);
            wait_idle();
        end

        if (tracker.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[control_word_frame_builder_unit.f]
design/cwfb_pkg.sv
design/cwfb_front.sv
design/cwfb_queue.sv
design/cwfb_back.sv
design/control_word_frame_builder_unit.sv
tb/sv/tb.sv
